/* src/m3fa_pkg.sv */
// m3fa_pkg: shared request codes, field widths, parameter defaults and the
// controller/datapath command and status types of the 3x3 matrix unit.
// No dependencies.
package m3fa_pkg;

  // Fixed field widths of the request transaction
  localparam int REQ_W = 4;
  localparam int IDX_W = 2;

  // Defaults for the top-level parameters
  localparam int DIM_DEF        = 3;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_A   = 4'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B   = 4'd1;
  localparam logic [REQ_W-1:0] REQ_ADD      = 4'd2;
  localparam logic [REQ_W-1:0] REQ_SUB      = 4'd3;
  localparam logic [REQ_W-1:0] REQ_MUL      = 4'd4;
  localparam logic [REQ_W-1:0] REQ_NEGATE   = 4'd5;
  localparam logic [REQ_W-1:0] REQ_COMPARE  = 4'd6;
  localparam logic [REQ_W-1:0] REQ_READ     = 4'd7;
  localparam logic [REQ_W-1:0] REQ_IDENTITY = 4'd8;

  // Controller to datapath: at most one command bit per cycle
  typedef struct packed {
    logic capture;    // latch the request, clear flags and counters
    logic load_elem;  // write one element of A or B
    logic set_ident;  // A back to identity
    logic ew_read;    // read A[e], B[e]
    logic ew_write;   // elementwise update or compare of element e
    logic mac_read;   // read A[i][k], B[k][j]
    logic mac_load;   // take operand magnitudes into the multiplier
    logic mac_step;   // one partial product
    logic mac_scale;  // shift, round and saturate the product
    logic mac_acc;    // saturating add into the running sum
    logic mac_write;  // sum to scratch[i][j]
    logic cp_read;    // read scratch[e]
    logic cp_write;   // scratch[e] to A[e]
    logic rd_read;    // read A at the request index
    logic rd_take;    // register the read result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             e_last;
    logic             k_last;
    logic             ij_last;
    logic             mul_last;
  } status_t;

endpackage

/* src/m3fa_req_if.sv */
// m3fa_req_if: request channel (valid/ready plus request payload).
// Depends on m3fa_pkg.
interface m3fa_req_if #(
  parameter int DATA_WIDTH = m3fa_pkg::DATA_WIDTH_DEF
) ();
  import m3fa_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [REQ_W-1:0]             req_type;
  logic [IDX_W-1:0]             row;
  logic [IDX_W-1:0]             col;
  logic signed [DATA_WIDTH-1:0] value;

  modport source (output valid, req_type, row, col, value, input ready);
  modport sink   (input valid, req_type, row, col, value, output ready);
endinterface

/* src/m3fa_rsp_if.sv */
// m3fa_rsp_if: result channel (valid/ready plus result payload).
// Depends on m3fa_pkg.
interface m3fa_rsp_if #(
  parameter int DATA_WIDTH = m3fa_pkg::DATA_WIDTH_DEF
) ();
  import m3fa_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] read_value;
  logic                         is_equal;
  logic                         saturated;

  modport source (output valid, read_value, is_equal, saturated, input ready);
  modport sink   (input valid, read_value, is_equal, saturated, output ready);
endinterface

/* src/m3fa_ram.sv */
// m3fa_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module m3fa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* src/m3fa_ctrl.sv */
// m3fa_ctrl: request sequencer of the matrix unit; drives at most one datapath
// command per cycle and the channel handshakes. Depends on m3fa_pkg.
module m3fa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output m3fa_pkg::cmd_t    cmd,
  input  m3fa_pkg::status_t status
);
  import m3fa_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_EW_RD     = 4'd2;
  localparam logic [3:0] S_EW_WR     = 4'd3;
  localparam logic [3:0] S_MAC_RD    = 4'd4;
  localparam logic [3:0] S_MAC_LAT   = 4'd5;
  localparam logic [3:0] S_MAC_MUL   = 4'd6;
  localparam logic [3:0] S_MAC_SCALE = 4'd7;
  localparam logic [3:0] S_MAC_ACC   = 4'd8;
  localparam logic [3:0] S_MAC_WR    = 4'd9;
  localparam logic [3:0] S_CP_RD     = 4'd10;
  localparam logic [3:0] S_CP_WR     = 4'd11;
  localparam logic [3:0] S_RD_WAIT   = 4'd12;
  localparam logic [3:0] S_RESP      = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_RESP);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (status.req)
          REQ_LOAD_A, REQ_LOAD_B: begin
            cmd.load_elem = 1'b1;
            state_next    = S_RESP;
          end
          REQ_ADD, REQ_SUB, REQ_NEGATE, REQ_COMPARE: begin
            cmd.ew_read = 1'b1;
            state_next  = S_EW_WR;
          end
          REQ_MUL: begin
            cmd.mac_read = 1'b1;
            state_next   = S_MAC_LAT;
          end
          REQ_READ: begin
            cmd.rd_read = 1'b1;
            state_next  = S_RD_WAIT;
          end
          REQ_IDENTITY: begin
            cmd.set_ident = 1'b1;
            state_next    = S_RESP;
          end
          default: begin
            state_next = S_RESP;
          end
        endcase
      end
      S_EW_RD: begin
        cmd.ew_read = 1'b1;
        state_next  = S_EW_WR;
      end
      S_EW_WR: begin
        cmd.ew_write = 1'b1;
        state_next   = status.e_last ? S_RESP : S_EW_RD;
      end
      S_MAC_RD: begin
        cmd.mac_read = 1'b1;
        state_next   = S_MAC_LAT;
      end
      S_MAC_LAT: begin
        cmd.mac_load = 1'b1;
        state_next   = S_MAC_MUL;
      end
      S_MAC_MUL: begin
        cmd.mac_step = 1'b1;
        if (status.mul_last) begin
          state_next = S_MAC_SCALE;
        end
      end
      S_MAC_SCALE: begin
        cmd.mac_scale = 1'b1;
        state_next    = S_MAC_ACC;
      end
      S_MAC_ACC: begin
        cmd.mac_acc = 1'b1;
        state_next  = status.k_last ? S_MAC_WR : S_MAC_RD;
      end
      S_MAC_WR: begin
        cmd.mac_write = 1'b1;
        state_next    = status.ij_last ? S_CP_RD : S_MAC_RD;
      end
      S_CP_RD: begin
        cmd.cp_read = 1'b1;
        state_next  = S_CP_WR;
      end
      S_CP_WR: begin
        cmd.cp_write = 1'b1;
        state_next   = status.e_last ? S_RESP : S_CP_RD;
      end
      S_RD_WAIT: begin
        cmd.rd_take = 1'b1;
        state_next  = S_RESP;
      end
      S_RESP: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

/* src/m3fa_dp.sv */
// m3fa_dp: datapath of the matrix unit: A, B and scratch RAMs, element
// counters, saturating add/sub/negate and a shared multiply-accumulate.
// Depends on m3fa_pkg and m3fa_ram.
module m3fa_dp #(
  parameter int DIM        = m3fa_pkg::DIM_DEF,
  parameter int DATA_WIDTH = m3fa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3fa_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  m3fa_pkg::cmd_t                cmd,
  output m3fa_pkg::status_t             status,
  input  logic [m3fa_pkg::REQ_W-1:0]    req_type,
  input  logic [m3fa_pkg::IDX_W-1:0]    row,
  input  logic [m3fa_pkg::IDX_W-1:0]    col,
  input  logic signed [DATA_WIDTH-1:0]  value,
  output logic signed [DATA_WIDTH-1:0]  read_value,
  output logic                          is_equal,
  output logic                          saturated
);
  import m3fa_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int CELLS = DIM * DIM;
  localparam int EW    = $clog2(CELLS);
  localparam int IW    = $clog2(DIM);
  // Multiplier split: operands above 32 bits go through in two halves
  localparam int PARTS = (DATA_WIDTH > 32) ? 2 : 1;
  localparam int PW    = (DATA_WIDTH + PARTS - 1) / PARTS;
  localparam int MW    = PARTS * PW;
  localparam int PRW   = 2 * MW;
  localparam int NSTEP = PARTS * PARTS;
  localparam int SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  localparam logic [DW-1:0]  VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]  VMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0]  ONE  = (FRAC_BITS >= DATA_WIDTH - 1) ? VMAX :
                                    (DW'(1) << FRAC_BITS);
  localparam logic [PRW-1:0] FRAC_MASK = ~({PRW{1'b1}} << FRAC_BITS);
  localparam logic [PRW-1:0] LIM_POS   = PRW'(VMAX);
  localparam logic [PRW-1:0] LIM_NEG   = PRW'(VMAX) + PRW'(1);

  function automatic logic [CELLS-1:0] diag_mask();
    logic [CELLS-1:0] m;
    m = '0;
    for (int n = 0; n < DIM; n++) begin
      m[n*DIM+n] = 1'b1;
    end
    return m;
  endfunction

  localparam logic [CELLS-1:0] DIAG = diag_mask();

  // Saturating helpers: result is {overflow flag, value}
  function automatic logic [DW:0] sat_add(input logic [DW-1:0] x, input logic [DW-1:0] y);
    logic [DW:0] s;
    s = {x[DW-1], x} + {y[DW-1], y};
    if (s[DW] != s[DW-1]) begin
      return {1'b1, (s[DW] ? VMIN : VMAX)};
    end
    return {1'b0, s[DW-1:0]};
  endfunction

  function automatic logic [DW:0] sat_sub(input logic [DW-1:0] x, input logic [DW-1:0] y);
    logic [DW:0] s;
    s = {x[DW-1], x} - {y[DW-1], y};
    if (s[DW] != s[DW-1]) begin
      return {1'b1, (s[DW] ? VMIN : VMAX)};
    end
    return {1'b0, s[DW-1:0]};
  endfunction

  function automatic logic [DW:0] sat_neg(input logic [DW-1:0] x);
    if (x == VMIN) begin
      return {1'b1, VMAX};
    end
    return {1'b0, -x};
  endfunction

  // Latched request
  logic [REQ_W-1:0] req_q;
  logic [IDX_W-1:0] row_q;
  logic [IDX_W-1:0] col_q;
  logic [DW-1:0]    value_q;

  // Counters
  logic [EW-1:0] e;
  logic [IW-1:0] i, j, k;

  // Per-entry written marks and their registered read copies
  logic [CELLS-1:0] a_valid, b_valid;
  logic             a_rvalid, a_rdiag, b_rvalid;

  // RAM ports
  logic          a_we, b_we, s_we;
  logic [EW-1:0] a_waddr, a_raddr, b_raddr, s_waddr, b_waddr;
  logic [DW-1:0] a_wdata, a_q, b_q, s_q;

  // Multiplier and accumulator
  logic [MW-1:0]   mag_a, mag_b;
  logic            neg;
  logic [PRW-1:0]  prod;
  logic [SW-1:0]   step;
  logic [DW-1:0]   pval;
  logic [DW-1:0]   sum;

  // Result registers
  logic [DW-1:0] rd_val;
  logic          eq;
  logic          sat;

  logic          in_range;
  logic [EW-1:0] req_idx, a_mac, b_mac, s_mac;
  logic          e_last, k_last, j_last, i_last;
  logic [DW-1:0] a_data, b_data, mag_ad, mag_bd;
  logic [DW:0]   ew_res, acc_res;
  logic [2*PW-1:0] pp;
  int              pa, pb;
  logic [PRW-1:0]  q, qa, nq;
  logic            rem, over;

  // Index decode
  assign in_range = (int'(row_q) < DIM) && (int'(col_q) < DIM);
  assign req_idx  = EW'(int'(row_q) * DIM + int'(col_q));
  assign a_mac    = EW'(int'(i) * DIM + int'(k));
  assign b_mac    = EW'(int'(k) * DIM + int'(j));
  assign s_mac    = EW'(int'(i) * DIM + int'(j));
  assign e_last   = (e == EW'(CELLS - 1));
  assign k_last   = (k == IW'(DIM - 1));
  assign j_last   = (j == IW'(DIM - 1));
  assign i_last   = (i == IW'(DIM - 1));

  assign status.req      = req_q;
  assign status.e_last   = e_last;
  assign status.k_last   = k_last;
  assign status.ij_last  = i_last && j_last;
  assign status.mul_last = (int'(step) == NSTEP - 1);

  // Unwritten A entries read as identity, unwritten B entries as zero
  assign a_data = a_rvalid ? a_q : (a_rdiag ? ONE : '0);
  assign b_data = b_rvalid ? b_q : '0;

  // Elementwise operation
  always_comb begin
    unique case (req_q)
      REQ_ADD: ew_res = sat_add(a_data, b_data);
      REQ_SUB: ew_res = sat_sub(a_data, b_data);
      default: ew_res = sat_neg(a_data);
    endcase
  end

  // A port selection
  always_comb begin
    a_we    = 1'b0;
    a_waddr = e;
    a_wdata = ew_res[DW-1:0];
    if (cmd.load_elem && req_q == REQ_LOAD_A && in_range) begin
      a_we    = 1'b1;
      a_waddr = req_idx;
      a_wdata = value_q;
    end else if (cmd.ew_write && req_q != REQ_COMPARE) begin
      a_we = 1'b1;
    end else if (cmd.cp_write) begin
      a_we    = 1'b1;
      a_wdata = s_q;
    end
    if (cmd.mac_read) begin
      a_raddr = a_mac;
    end else if (cmd.rd_read) begin
      a_raddr = req_idx;
    end else begin
      a_raddr = e;
    end
  end

  assign b_we    = cmd.load_elem && req_q == REQ_LOAD_B && in_range;
  assign b_waddr = req_idx;
  assign b_raddr = cmd.mac_read ? b_mac : e;
  assign s_we    = cmd.mac_write;
  assign s_waddr = s_mac;

  m3fa_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_q)
  );

  m3fa_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_b_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(value_q), .raddr(b_raddr), .rdata(b_q)
  );

  m3fa_ram #(.WIDTH(DW), .DEPTH(CELLS)) u_s_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(sum), .raddr(e), .rdata(s_q)
  );

  // Written marks; identity simply forgets every A entry
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= '0;
      b_valid <= '0;
    end else begin
      if (cmd.set_ident) begin
        a_valid <= '0;
      end else if (a_we) begin
        a_valid[a_waddr] <= 1'b1;
      end
      if (b_we) begin
        b_valid[b_waddr] <= 1'b1;
      end
    end
  end

  // Marks travel with the registered read data
  always_ff @(posedge clk) begin
    a_rvalid <= a_valid[a_raddr];
    a_rdiag  <= DIAG[a_raddr];
    b_rvalid <= b_valid[b_raddr];
  end

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q   <= req_type;
      row_q   <= row;
      col_q   <= col;
      value_q <= value;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (rst || cmd.capture) begin
      e <= '0;
      i <= '0;
      j <= '0;
      k <= '0;
    end else begin
      if (cmd.ew_write || cmd.cp_write) begin
        e <= e_last ? '0 : e + EW'(1);
      end
      if (cmd.mac_acc) begin
        k <= k_last ? '0 : k + IW'(1);
      end
      if (cmd.mac_write) begin
        if (j_last) begin
          j <= '0;
          i <= i + IW'(1);
        end else begin
          j <= j + IW'(1);
        end
      end
    end
  end

  // Multiplier: one partial product of at most PW x PW bits per cycle
  assign mag_ad = a_data[DW-1] ? -a_data : a_data;
  assign mag_bd = b_data[DW-1] ? -b_data : b_data;

  always_comb begin
    pa = int'(step) % PARTS;
    pb = int'(step) / PARTS;
    pp = mag_a[pa*PW +: PW] * mag_b[pb*PW +: PW];
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_load) begin
      mag_a <= MW'(mag_ad);
      mag_b <= MW'(mag_bd);
      neg   <= a_data[DW-1] ^ b_data[DW-1];
      prod  <= '0;
      step  <= '0;
    end else if (cmd.mac_step) begin
      prod <= prod + (PRW'(pp) << ((pa + pb) * PW));
      step <= step + SW'(1);
    end
  end

  // Scale: drop fraction bits (toward minus infinity), then saturate
  always_comb begin
    q    = prod >> FRAC_BITS;
    rem  = |(prod & FRAC_MASK);
    qa   = q + PRW'(neg && rem);
    nq   = -qa;
    over = neg ? (qa > LIM_NEG) : (qa > LIM_POS);
  end

  assign acc_res = sat_add((k == '0) ? '0 : sum, pval);

  always_ff @(posedge clk) begin
    if (cmd.mac_scale) begin
      if (over) begin
        pval <= neg ? VMIN : VMAX;
      end else begin
        pval <= neg ? nq[DW-1:0] : qa[DW-1:0];
      end
    end
    if (cmd.mac_acc) begin
      sum <= acc_res[DW-1:0];
    end
  end

  // Result flags and read value
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_val <= '0;
      eq     <= 1'b0;
      sat    <= 1'b0;
    end else if (cmd.capture) begin
      rd_val <= '0;
      eq     <= (req_type == REQ_COMPARE);
      sat    <= 1'b0;
    end else begin
      if (cmd.ew_write) begin
        if (req_q == REQ_COMPARE) begin
          if (a_data != b_data) begin
            eq <= 1'b0;
          end
        end else if (ew_res[DW]) begin
          sat <= 1'b1;
        end
      end
      if ((cmd.mac_scale && over) || (cmd.mac_acc && acc_res[DW])) begin
        sat <= 1'b1;
      end
      if (cmd.rd_take) begin
        rd_val <= in_range ? a_data : '0;
      end
    end
  end

  assign read_value = rd_val;
  assign is_equal   = eq;
  assign saturated  = sat;
endmodule

/* src/matrix3x3_fixed_alu.sv */
// matrix3x3_fixed_alu: top level of a DIM x DIM signed fixed-point matrix unit
// (Q16.16 by default) built from m3fa_ctrl, m3fa_dp and m3fa_ram, using
// m3fa_pkg and the m3fa_req_if / m3fa_rsp_if channels. The unit holds an
// accumulator matrix A (identity after reset) and an operand matrix B (zero
// after reset); every request transaction produces exactly one result
// transaction, and one request is processed at a time. The next request can
// be accepted in the cycle after the result is taken. A multiply is done by
// the single shared multiply-accumulate unit, which for each term reads A and
// B from RAM, loads the operand magnitudes, forms the partial products one at
// a time (one for DATA_WIDTH up to 32, four above), scales the product and
// accumulates it; the sums go to a scratch RAM that is then copied back into A.
// Sums, differences, products and negation saturate and set the saturated
// flag of that result.
module matrix3x3_fixed_alu #(
  parameter int DIM        = m3fa_pkg::DIM_DEF,
  parameter int DATA_WIDTH = m3fa_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = m3fa_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  m3fa_req_if.sink    req,
  m3fa_rsp_if.source  rsp
);
  import m3fa_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequencer
  m3fa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Storage and arithmetic
  m3fa_dp #(
    .DIM        (DIM),
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .req_type   (req.req_type),
    .row        (req.row),
    .col        (req.col),
    .value      (req.value),
    .read_value (rsp.read_value),
    .is_equal   (rsp.is_equal),
    .saturated  (rsp.saturated)
  );

  // One transaction in flight: never ready for a request while a result waits
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request ready while result pending");

  // An accepted request closes the input until its result is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request ready right after accept");

  // The sequencer issues at most one datapath command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  // Compare never saturates, so both flags cannot be set together
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.is_equal && rsp.saturated))
    else $error("is_equal and saturated both set");
endmodule

/* tb/sv/tb_matrix3x3_fixed_alu.sv */
`timescale 1ns / 1ps
// tb_matrix3x3_fixed_alu: self-checking bench for the 3x3 Q16.16 matrix unit.
// A directed table, then random requests, checked against an in-bench predictor.
// Depends on m3fa_pkg, m3fa_req_if, m3fa_rsp_if and matrix3x3_fixed_alu.
module tb_matrix3x3_fixed_alu;
  import m3fa_pkg::*;

  localparam int DW    = DATA_WIDTH_DEF;
  localparam int FB    = FRAC_BITS_DEF;
  localparam int N     = DIM_DEF;
  localparam int CELLS = N * N;

  localparam int N_DIRECTED      = 25;
  localparam int N_RANDOM        = 1425;
  localparam int TAIL_ITEMS      = 150;
  localparam int HOLD_OFF_AT     = 600;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT  = 4000;

  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 4'd9;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 4'd15;
  localparam logic [IDX_W-1:0] IDX_OOB          = 2'd3;

  localparam logic signed [DW-1:0] Q_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] Q_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] Q_ONE = DW'(1) << FB;

  typedef struct {
    logic [REQ_W-1:0]     kind;
    logic [IDX_W-1:0]     row;
    logic [IDX_W-1:0]     col;
    logic signed [DW-1:0] value;
    bit                   typed;     // expected result given by hand
    logic signed [DW-1:0] want_rd;
    bit                   want_eq;
    bit                   want_sat;
  } alu_req_t;

  typedef struct {
    logic signed [DW-1:0] read_value;
    bit                   is_equal;
    bit                   saturated;
  } alu_rsp_t;

  logic clk;
  logic rst;

  m3fa_req_if #(.DATA_WIDTH(DW)) req_ch ();
  m3fa_rsp_if #(.DATA_WIDTH(DW)) rsp_ch ();

  matrix3x3_fixed_alu u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Request payload follows the transaction being offered
  alu_req_t cur_req;
  assign req_ch.req_type = cur_req.kind;
  assign req_ch.row      = cur_req.row;
  assign req_ch.col      = cur_req.col;
  assign req_ch.value    = cur_req.value;

  // Predictor state: accumulator A and operand B
  logic signed [DW-1:0] acc_q [CELLS];
  logic signed [DW-1:0] opd_q [CELLS];

  alu_rsp_t expected_rsp_q [$];
  int       mismatches = 0;
  int       stall_cycles;
  int       sent_count;
  bit       idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Saturate a wide value to the signed data range
  function automatic logic signed [DW-1:0] clamp_q(input logic signed [2*DW-1:0] v,
                                                   inout bit ovf);
    if (v > Q_MAX) begin
      ovf = 1'b1;
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      ovf = 1'b1;
      return Q_MIN;
    end
    return v[DW-1:0];
  endfunction

  function automatic void set_identity();
    for (int e = 0; e < CELLS; e++)
      acc_q[e] = (e / N == e % N) ? Q_ONE : '0;
  endfunction

  // Apply one request to the predictor state and return its result
  function automatic alu_rsp_t apply_request(input alu_req_t r);
    alu_rsp_t             res;
    bit                   in_rng;
    bit                   ovf;
    int                   idx;
    logic signed [2*DW-1:0] w;
    logic signed [DW-1:0] sum;
    logic signed [DW-1:0] term;
    logic signed [DW-1:0] scratch [CELLS];
    res.read_value = '0;
    res.is_equal   = 1'b0;
    ovf            = 1'b0;
    in_rng = (r.row < N) && (r.col < N);
    idx    = in_rng ? r.row * N + r.col : 0;
    case (r.kind)
      REQ_LOAD_A: begin
        if (in_rng) acc_q[idx] = r.value;
      end
      REQ_LOAD_B: begin
        if (in_rng) opd_q[idx] = r.value;
      end
      REQ_ADD: begin
        for (int e = 0; e < CELLS; e++) begin
          w = acc_q[e];
          w = w + opd_q[e];
          acc_q[e] = clamp_q(w, ovf);
        end
      end
      REQ_SUB: begin
        for (int e = 0; e < CELLS; e++) begin
          w = acc_q[e];
          w = w - opd_q[e];
          acc_q[e] = clamp_q(w, ovf);
        end
      end
      REQ_MUL: begin
        // product floored to the fraction, saturated, then saturating sum
        for (int i = 0; i < N; i++) begin
          for (int j = 0; j < N; j++) begin
            sum = '0;
            for (int k = 0; k < N; k++) begin
              w = acc_q[i*N+k];
              w = w * opd_q[k*N+j];
              w = w >>> FB;
              term = clamp_q(w, ovf);
              w = sum;
              w = w + term;
              sum = clamp_q(w, ovf);
            end
            scratch[i*N+j] = sum;
          end
        end
        acc_q = scratch;
      end
      REQ_NEGATE: begin
        for (int e = 0; e < CELLS; e++) begin
          w = acc_q[e];
          w = -w;
          acc_q[e] = clamp_q(w, ovf);
        end
      end
      REQ_COMPARE: begin
        res.is_equal = 1'b1;
        for (int e = 0; e < CELLS; e++)
          if (acc_q[e] != opd_q[e]) res.is_equal = 1'b0;
      end
      REQ_READ: begin
        if (in_rng) res.read_value = acc_q[idx];
      end
      REQ_IDENTITY: set_identity();
      default: ;
    endcase
    res.saturated = ovf;
    return res;
  endfunction

  // Scoreboard: check results, predict on accepted requests, track stalls
  always @(posedge clk) begin : scoreboard
    alu_rsp_t want;
    alu_rsp_t pred;
    bit       moved;
    if (rst) begin
      set_identity();
      for (int e = 0; e < CELLS; e++) opd_q[e] = '0;
      stall_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (rsp_ch.valid && rsp_ch.ready) begin
        moved = 1'b1;
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: result with nothing expected: read_value %h is_equal %b saturated %b",
                   $time, rsp_ch.read_value, rsp_ch.is_equal, rsp_ch.saturated);
          mismatches++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_ch.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, rsp_ch.read_value);
            mismatches++;
          end
          if (rsp_ch.is_equal !== want.is_equal) begin
            $display("%0t: is_equal expected %b actual %b",
                     $time, want.is_equal, rsp_ch.is_equal);
            mismatches++;
          end
          if (rsp_ch.saturated !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b",
                     $time, want.saturated, rsp_ch.saturated);
            mismatches++;
          end
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        moved = 1'b1;
        pred = apply_request(cur_req);
        if (cur_req.typed) begin
          want.read_value = cur_req.want_rd;
          want.is_equal   = cur_req.want_eq;
          want.saturated  = cur_req.want_sat;
          expected_rsp_q.push_back(want);
        end else begin
          expected_rsp_q.push_back(pred);
        end
      end
      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog on cycles with no transaction on either side
  initial begin
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("tb_matrix3x3_fixed_alu NOT OK");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off once enough requests went in
  initial begin
    bit hold_off_done;
    hold_off_done = 1'b0;
    rsp_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_off_done && sent_count >= HOLD_OFF_AT) begin
        hold_off_done = 1'b1;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offer one request and hold it until accepted; called at a falling edge
  task automatic push_request(input alu_req_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    cur_req      <= it;
    do @(posedge clk); while (!req_ch.ready);
    sent_count++;
  endtask

  function automatic alu_req_t tab_row(input logic [REQ_W-1:0] kind,
                                       input logic [IDX_W-1:0] row,
                                       input logic [IDX_W-1:0] col,
                                       input logic signed [DW-1:0] value,
                                       input bit typed,
                                       input logic signed [DW-1:0] rd,
                                       input bit eq,
                                       input bit sat);
    alu_req_t t;
    t.kind = kind;  t.row = row;  t.col = col;  t.value = value;
    t.typed = typed;  t.want_rd = rd;  t.want_eq = eq;  t.want_sat = sat;
    return t;
  endfunction

  // Mix of small values (so products stay in range), full-range and extremes
  function automatic logic signed [DW-1:0] rand_value();
    int v;
    case ($urandom_range(0, 7))
      0, 1, 2, 3: begin
        v = $urandom_range(0, 1 << (FB + 3));
        v = v - (1 << (FB + 2));
      end
      4, 5: v = $urandom;
      6: begin
        case ($urandom_range(0, 6))
          0: v = Q_MAX;
          1: v = Q_MIN;
          2: v = 0;
          3: v = Q_ONE;
          4: v = -Q_ONE;
          5: v = 1;
          default: v = -1;
        endcase
      end
      default: begin
        v = $urandom_range(0, 1 << FB);
        v = v - (1 << (FB - 1));
      end
    endcase
    return v;
  endfunction

  function automatic alu_req_t rand_request();
    alu_req_t t;
    int       pick;
    t = tab_row(REQ_READ, '0, '0, rand_value(), 1'b0, '0, 1'b0, 1'b0);
    if ($urandom_range(0, 15) == 0) begin
      t.row = IDX_W'($urandom_range(0, 3));
      t.col = IDX_W'($urandom_range(0, 3));
    end else begin
      t.row = IDX_W'($urandom_range(0, N - 1));
      t.col = IDX_W'($urandom_range(0, N - 1));
    end
    pick = $urandom_range(0, 92);
    if      (pick < 22) t.kind = REQ_LOAD_A;
    else if (pick < 44) t.kind = REQ_LOAD_B;
    else if (pick < 50) t.kind = REQ_ADD;
    else if (pick < 55) t.kind = REQ_SUB;
    else if (pick < 63) t.kind = REQ_MUL;
    else if (pick < 66) t.kind = REQ_NEGATE;
    else if (pick < 71) t.kind = REQ_COMPARE;
    else if (pick < 88) t.kind = REQ_READ;
    else if (pick < 91) t.kind = REQ_IDENTITY;
    else t.kind = REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
    return t;
  endfunction

  // Stimulus
  initial begin
    alu_req_t dir_tab [N_DIRECTED];
    alu_req_t it;
    logic signed [DW-1:0] snap [CELLS];
    int       bad_cell;

    rst          = 1'b1;
    req_ch.valid = 1'b0;
    cur_req      = tab_row(REQ_LOAD_A, '0, '0, '0, 1'b0, '0, 1'b0, 1'b0);
    sent_count   = 0;
    idle_on      = 1'b1;

    // directed: reset values, compare both ways, out-of-range index,
    // unused codes, negate/add/sub saturation, multiply, identity
    dir_tab[0]  = tab_row(REQ_READ, 2'd0, 2'd0, '0, 1'b1, Q_ONE, 1'b0, 1'b0);
    dir_tab[1]  = tab_row(REQ_READ, 2'd1, 2'd0, '0, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[2]  = tab_row(REQ_COMPARE, 2'd0, 2'd0, '0, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[3]  = tab_row(REQ_LOAD_B, 2'd0, 2'd0, Q_ONE, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[4]  = tab_row(REQ_LOAD_B, 2'd1, 2'd1, Q_ONE, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[5]  = tab_row(REQ_LOAD_B, 2'd2, 2'd2, Q_ONE, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[6]  = tab_row(REQ_COMPARE, 2'd0, 2'd0, '0, 1'b1, '0, 1'b1, 1'b0);
    dir_tab[7]  = tab_row(REQ_MUL, 2'd0, 2'd0, '0, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[8]  = tab_row(REQ_COMPARE, 2'd0, 2'd0, '0, 1'b1, '0, 1'b1, 1'b0);
    dir_tab[9]  = tab_row(REQ_LOAD_B, IDX_OOB, 2'd0, '1, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[10] = tab_row(REQ_COMPARE, 2'd0, 2'd0, '0, 1'b1, '0, 1'b1, 1'b0);
    dir_tab[11] = tab_row(REQ_READ, 2'd0, IDX_OOB, '0, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[12] = tab_row(REQ_UNUSED_FIRST, 2'd1, 2'd2, Q_ONE, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[13] = tab_row(REQ_UNUSED_LAST, IDX_OOB, IDX_OOB, '1, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[14] = tab_row(REQ_LOAD_A, 2'd0, 2'd0, Q_MIN, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[15] = tab_row(REQ_NEGATE, 2'd0, 2'd0, '0, 1'b1, '0, 1'b0, 1'b1);
    dir_tab[16] = tab_row(REQ_READ, 2'd0, 2'd0, '0, 1'b1, Q_MAX, 1'b0, 1'b0);
    dir_tab[17] = tab_row(REQ_LOAD_B, 2'd0, 2'd0, Q_MAX, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[18] = tab_row(REQ_ADD, 2'd0, 2'd0, '0, 1'b1, '0, 1'b0, 1'b1);
    dir_tab[19] = tab_row(REQ_LOAD_B, 2'd0, 2'd1, Q_MIN, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[20] = tab_row(REQ_SUB, 2'd0, 2'd0, '0, 1'b1, '0, 1'b0, 1'b1);
    dir_tab[21] = tab_row(REQ_READ, 2'd0, 2'd1, '0, 1'b1, Q_MAX, 1'b0, 1'b0);
    dir_tab[22] = tab_row(REQ_MUL, 2'd0, 2'd0, '0, 1'b0, '0, 1'b0, 1'b0);
    dir_tab[23] = tab_row(REQ_IDENTITY, 2'd2, 2'd1, Q_MIN, 1'b1, '0, 1'b0, 1'b0);
    dir_tab[24] = tab_row(REQ_READ, 2'd1, 2'd1, '0, 1'b1, Q_ONE, 1'b0, 1'b0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) begin
      @(negedge clk);
      push_request(dir_tab[i]);
    end

    // random part
    while (sent_count < N_DIRECTED + N_RANDOM) begin
      @(negedge clk);
      if (sent_count >= N_DIRECTED + N_RANDOM - TAIL_ITEMS)
        idle_on = 1'b0;
      else if (sent_count % 40 == 0)
        idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 99) < 7) begin
        // copy A into B element by element, sometimes with one cell off,
        // then compare
        snap = acc_q;
        bad_cell = ($urandom_range(0, 2) == 0) ? $urandom_range(0, CELLS - 1) : -1;
        for (int e = 0; e < CELLS; e++) begin
          if (e != 0) @(negedge clk);
          it = tab_row(REQ_LOAD_B, IDX_W'(e / N), IDX_W'(e % N), snap[e],
                       1'b0, '0, 1'b0, 1'b0);
          if (e == bad_cell) it.value = it.value ^ (DW'(1) << $urandom_range(0, DW - 1));
          push_request(it);
        end
        @(negedge clk);
        it = tab_row(REQ_COMPARE, '0, '0, rand_value(), 1'b0, '0, 1'b0, 1'b0);
        push_request(it);
      end else begin
        push_request(rand_request());
      end
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_matrix3x3_fixed_alu OK");
    end else begin
      $display("tb_matrix3x3_fixed_alu NOT OK");
    end
    $finish;
  end

endmodule
